// ----- hdl/dwr_pkg.sv -----
// ----------------------------------------------------------------------------
// dwr_pkg
// shared sizes, result codes and controller/datapath interface types for the
// device window remap table
// ----------------------------------------------------------------------------
package dwr_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PAGE_LOG2     = 12;
  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 5;
  localparam int COUNT_W       = 12;
  localparam int STATUS_W      = 3;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int IDX_W         = SLOT_W + 1;
  localparam int PN_W          = ADDR_W - PAGE_LOG2;
  localparam int ENTRY_W       = PN_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(PAGE_LOG2);

  // request kinds
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic start;   // capture request, restart scan
    logic scan;    // step the table scan
    logic commit;  // write back and load result
  } dwr_cmd_t;

  typedef struct packed {
    logic too_large;  // size check on the incoming word
    logic scan_done;
  } dwr_sts_t;

endpackage

// ----- hdl/dwr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dwr_ctrl
// request sequencer: accepts a word, runs the table scan (skipped for an
// oversized word), commits the result into the output register when it is free
// ----------------------------------------------------------------------------
module dwr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dwr_pkg::dwr_sts_t sts,
  output dwr_pkg::dwr_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign cmd.start  = accept;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.commit = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // oversized requests skip the scan
          state_next = sts.too_large ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result committed over a held word");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("not busy after accepting a word");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result word appeared without a commit");

endmodule

// ----- hdl/dwr_datapath.sv -----
// ----------------------------------------------------------------------------
// dwr_datapath
// request registers, entry memory with live bits, scan logic, result
// computation and the output register
// ----------------------------------------------------------------------------
module dwr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dwr_pkg::dwr_cmd_t                 cmd,
  output dwr_pkg::dwr_sts_t                 sts,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dwr_pkg::ADDR_W-1:0]        cfg_data,
  input  logic                              op,
  input  logic [dwr_pkg::ADDR_W-1:0]        dev_addr,
  input  logic [dwr_pkg::SIZE_W-1:0]        size_log2,
  input  logic                              keep_reference,
  output logic [dwr_pkg::STATUS_W-1:0]      status,
  output logic [dwr_pkg::SLOT_W-1:0]        slot_index,
  output logic [dwr_pkg::ADDR_W-1:0]        win_addr,
  output logic                              flushed,
  output logic [dwr_pkg::COUNT_W-1:0]       ref_count
);

  localparam int SLOT_W  = dwr_pkg::SLOT_W;
  localparam int IDX_W   = dwr_pkg::IDX_W;
  localparam int PN_W    = dwr_pkg::PN_W;
  localparam int COUNT_W = dwr_pkg::COUNT_W;
  localparam int PAGE_W  = dwr_pkg::PAGE_LOG2;
  localparam int ADDR_W  = dwr_pkg::ADDR_W;
  localparam int PAD_W   = ADDR_W - SLOT_W - PAGE_W;
  localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(dwr_pkg::TABLE_ENTRIES);

  logic [ADDR_W-1:0] window_base;

  // entry: page number over count
  logic [dwr_pkg::ENTRY_W-1:0]         mem [dwr_pkg::TABLE_ENTRIES];
  logic [dwr_pkg::TABLE_ENTRIES-1:0]   live;

  // captured request
  logic              req_op;
  logic              req_keep;
  logic              req_big;
  logic [PN_W-1:0]   req_pn;
  logic [PAGE_W-1:0] req_off;

  // scan
  logic [IDX_W-1:0]            idx;
  logic                        rd_valid;
  logic [dwr_pkg::ENTRY_W-1:0] rd_entry;
  logic                        rd_live;
  logic [SLOT_W-1:0]           rd_slot;
  logic                        hit;
  logic [SLOT_W-1:0]           hit_slot;
  logic [COUNT_W-1:0]          hit_count;
  logic                        free_found;
  logic [SLOT_W-1:0]           free_slot;

  // result
  logic [SLOT_W-1:0]   res_slot;
  logic [COUNT_W-1:0]  cur_count;
  logic [COUNT_W-1:0]  new_count;
  logic [PAGE_W-1:0]   add_off;
  logic [ADDR_W-1:0]   slot_addr;
  logic                wr_en;
  logic                wr_live;
  logic [dwr_pkg::STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_index;
  logic                res_addr_en;
  logic                res_flushed;
  logic [COUNT_W-1:0]  res_count;

  assign cfg_ready     = 1'b1;
  assign sts.too_large = (size_log2 > dwr_pkg::SIZE_MAX);
  assign sts.scan_done = (idx == SCAN_END) && !rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      window_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op   <= op;
      req_keep <= keep_reference;
      req_big  <= sts.too_large;
      req_pn   <= dev_addr[ADDR_W-1:PAGE_W];
      req_off  <= dev_addr[PAGE_W-1:0];
    end
  end

  // memory read, one entry per scan cycle
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_entry <= mem[idx[SLOT_W-1:0]];
      rd_live  <= live[idx[SLOT_W-1:0]];
      rd_slot  <= idx[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[res_slot] <= {req_pn, new_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (wr_en) begin
      live[res_slot] <= wr_live;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_valid   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.start) begin
      idx        <= '0;
      rd_valid   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      if (idx != SCAN_END) begin
        idx <= idx + IDX_W'(1);
      end
      rd_valid <= (idx != SCAN_END);
      if (rd_valid) begin
        // first live match and first free slot, lowest index wins
        if (rd_live && !hit && (rd_entry[dwr_pkg::ENTRY_W-1:COUNT_W] == req_pn)) begin
          hit <= 1'b1;
        end
        if (!rd_live && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_valid) begin
      if (rd_live && !hit && (rd_entry[dwr_pkg::ENTRY_W-1:COUNT_W] == req_pn)) begin
        hit_slot  <= rd_slot;
        hit_count <= rd_entry[COUNT_W-1:0];
      end
      if (!rd_live && !free_found) begin
        free_slot <= rd_slot;
      end
    end
  end

  assign res_slot  = hit ? hit_slot : free_slot;
  assign cur_count = hit ? hit_count : '0;
  assign slot_addr = window_base + {{PAD_W{1'b0}}, res_slot, add_off};

  always_comb begin
    res_status  = dwr_pkg::STATUS_OK;
    res_index   = '0;
    res_addr_en = 1'b0;
    res_flushed = 1'b0;
    res_count   = '0;
    add_off     = req_off;
    new_count   = cur_count + COUNT_W'(1);
    wr_en       = 1'b0;
    wr_live     = 1'b1;
    if (req_big) begin
      res_status = dwr_pkg::STATUS_TOO_LARGE;
    end else if (req_op == dwr_pkg::OP_MAP) begin
      if (!hit && !free_found) begin
        res_status = dwr_pkg::STATUS_FULL;
      end else if (cur_count == dwr_pkg::COUNT_MAX) begin
        res_status = dwr_pkg::STATUS_OVERFLOW;
        res_index  = res_slot;
        res_count  = dwr_pkg::COUNT_MAX;
      end else begin
        res_index   = res_slot;
        res_count   = new_count;
        res_addr_en = 1'b1;
        wr_en       = cmd.commit;
      end
    end else begin
      new_count = cur_count - COUNT_W'(1);
      if (!hit) begin
        res_status = dwr_pkg::STATUS_NOT_FOUND;
      end else if (req_keep) begin
        res_index   = res_slot;
        res_count   = cur_count;
        res_addr_en = 1'b1;
        add_off     = '0;
      end else begin
        res_index   = res_slot;
        res_count   = new_count;
        res_addr_en = 1'b1;
        wr_en       = cmd.commit;
        wr_live     = (new_count != '0);
        if (new_count == '0) begin
          res_flushed = 1'b1;
          add_off     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= res_status;
      slot_index <= res_index;
      win_addr   <= res_addr_en ? slot_addr : '0;
      flushed    <= res_flushed;
      ref_count  <= res_count;
    end
  end

  a_write_commit: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> cmd.commit && !req_big)
    else $error("table written outside a commit");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= SCAN_END)
    else $error("scan index past table end");

  a_flush_frees: assert property (@(posedge clk) disable iff (rst)
    (wr_en && res_flushed) |=> !live[$past(res_slot)])
    else $error("flushed entry still live");

endmodule

// ----- hdl/device_window_remap_table.sv -----
// ----------------------------------------------------------------------------
// device_window_remap_table
// reference-counted table mapping device pages into a fixed address window
// ----------------------------------------------------------------------------
// a request word (op, dev_addr, size_log2, keep_reference) is taken on the
// input channel when in_valid is high and in_stall is low; one result word
// (status, slot_index, win_addr, flushed, ref_count) follows on the output
// channel, held until out_stall is low while out_valid is high.
// the window base is written through cfg_valid/cfg_ready/cfg_data, always
// ready, and should only change while no request is in flight.
// each request scans all 64 table entries through the single read port of
// the entry memory, one entry per cycle; after the read stage and the final
// step the result word is committed to the output register, and the next
// word can be taken in the same cycle as that result word is presented.
// an oversized request skips the scan and goes straight to the final step,
// and the next word can follow once its result is committed.
// one request is worked on at a time.
// a stalled receiver keeps its result word stable; if it still holds that
// word when the next scan ends, the block waits in its final step until the
// output register frees up.
// reset clears the window base and every live bit, so all entries are free;
// no clearing pass is needed and the block accepts a word right after reset.
// ----------------------------------------------------------------------------
module device_window_remap_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [dwr_pkg::ADDR_W-1:0]   dev_addr,
  input  logic [dwr_pkg::SIZE_W-1:0]   size_log2,
  input  logic                         keep_reference,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dwr_pkg::STATUS_W-1:0] status,
  output logic [dwr_pkg::SLOT_W-1:0]   slot_index,
  output logic [dwr_pkg::ADDR_W-1:0]   win_addr,
  output logic                         flushed,
  output logic [dwr_pkg::COUNT_W-1:0]  ref_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dwr_pkg::ADDR_W-1:0]   cfg_data
);

  dwr_pkg::dwr_cmd_t cmd;
  dwr_pkg::dwr_sts_t sts;

  dwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dwr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .op             (op),
    .dev_addr       (dev_addr),
    .size_log2      (size_log2),
    .keep_reference (keep_reference),
    .status         (status),
    .slot_index     (slot_index),
    .win_addr       (win_addr),
    .flushed        (flushed),
    .ref_count      (ref_count)
  );

endmodule
